// ----- hdl/nearest_address_top_k_top_defines.svh -----
// Assertion macros for the nearest address top-k block
`ifndef NEAREST_ADDRESS_TOP_K_TOP_DEFINES_SVH
`define NEAREST_ADDRESS_TOP_K_TOP_DEFINES_SVH

// same-cycle implication
`define NAT_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define NAT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ----- hdl/nat_pkg.sv -----
// Shared types and constants for the nearest address top-k block
`timescale 1ns / 1ps

package nat_pkg;

  localparam int MAX_KEEP_DEF = 16;
  localparam int ID_BITS_DEF  = 16;

  localparam int ADDR_W = 64;
  localparam int IDX_W  = 3;

  localparam logic [IDX_W-1:0] REG_MODE       = 3'd0;
  localparam logic [IDX_W-1:0] REG_QUERY      = 3'd1;
  localparam logic [IDX_W-1:0] REG_TEXT_START = 3'd2;
  localparam logic [IDX_W-1:0] REG_TEXT_LEN   = 3'd3;
  localparam logic [IDX_W-1:0] REG_KEEP       = 3'd4;

  localparam logic [4:0]  KEEP_RESET = 5'd5;
  localparam logic [11:0] CONF_SPAN  = 12'd4095;
  localparam logic [6:0]  CONF_FULL  = 7'd100;
  localparam logic [ADDR_W-1:0] PAGE_MASK = 64'hFFF;

  // control for every cell of the chain
  typedef struct packed {
    logic ins;
    logic pop;
    logic clr;
  } cell_ctl_t;

  // front end record status at the insert stage
  typedef struct packed {
    logic valid;
    logic ok;
    logic last;
  } stage_t;

endpackage

// ----- hdl/nat_cell.sv -----
// One cell of the sorted shift-insert chain
`timescale 1ns / 1ps

module nat_cell #(
  parameter int ID_BITS = nat_pkg::ID_BITS_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  input  nat_pkg::cell_ctl_t        ctl,
  input  logic [nat_pkg::ADDR_W-1:0] new_address,
  input  logic [nat_pkg::ADDR_W-1:0] new_distance,
  input  logic [ID_BITS-1:0]        new_id,
  input  logic                      prev_greater,
  input  logic                      prev_valid,
  input  logic [nat_pkg::ADDR_W-1:0] prev_address,
  input  logic [nat_pkg::ADDR_W-1:0] prev_distance,
  input  logic [ID_BITS-1:0]        prev_id,
  input  logic                      next_valid,
  input  logic [nat_pkg::ADDR_W-1:0] next_address,
  input  logic [nat_pkg::ADDR_W-1:0] next_distance,
  input  logic [ID_BITS-1:0]        next_id,
  output logic                      greater,
  output logic                      take_new,
  output logic                      valid,
  output logic [nat_pkg::ADDR_W-1:0] address,
  output logic [nat_pkg::ADDR_W-1:0] distance,
  output logic [ID_BITS-1:0]        id
);

  assign greater  = !valid || (distance > new_distance);
  assign take_new = ctl.ins && greater && !prev_greater;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (ctl.clr) begin
      valid <= 1'b0;
    end else if (ctl.pop) begin
      valid <= next_valid;
    end else if (take_new) begin
      valid <= 1'b1;
    end else if (ctl.ins && greater) begin
      valid <= prev_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.pop) begin
      address  <= next_address;
      distance <= next_distance;
      id       <= next_id;
    end else if (take_new) begin
      address  <= new_address;
      distance <= new_distance;
      id       <= new_id;
    end else if (ctl.ins && greater) begin
      address  <= prev_address;
      distance <= prev_distance;
      id       <= prev_id;
    end
  end

endmodule

// ----- hdl/nat_chain.sv -----
// Row of cells holding the kept entries in distance order
`timescale 1ns / 1ps

module nat_chain #(
  parameter int MAX_KEEP = nat_pkg::MAX_KEEP_DEF,
  parameter int ID_BITS  = nat_pkg::ID_BITS_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  nat_pkg::cell_ctl_t         ctl,
  input  logic [nat_pkg::ADDR_W-1:0] new_address,
  input  logic [nat_pkg::ADDR_W-1:0] new_distance,
  input  logic [ID_BITS-1:0]         new_id,
  output logic                       inserted,
  output logic [nat_pkg::ADDR_W-1:0] head_address,
  output logic [nat_pkg::ADDR_W-1:0] head_distance,
  output logic [ID_BITS-1:0]         head_id
);

  logic                       c_greater  [MAX_KEEP];
  logic                       c_take     [MAX_KEEP];
  logic                       c_valid    [MAX_KEEP];
  logic [nat_pkg::ADDR_W-1:0] c_address  [MAX_KEEP];
  logic [nat_pkg::ADDR_W-1:0] c_distance [MAX_KEEP];
  logic [ID_BITS-1:0]         c_id       [MAX_KEEP];
  logic [MAX_KEEP-1:0]        take_vec;

  for (genvar i = 0; i < MAX_KEEP; i++) begin : g_cell
    logic                       p_greater;
    logic                       p_valid;
    logic [nat_pkg::ADDR_W-1:0] p_address;
    logic [nat_pkg::ADDR_W-1:0] p_distance;
    logic [ID_BITS-1:0]         p_id;
    logic                       n_valid;
    logic [nat_pkg::ADDR_W-1:0] n_address;
    logic [nat_pkg::ADDR_W-1:0] n_distance;
    logic [ID_BITS-1:0]         n_id;

    if (i == 0) begin : g_first
      assign p_greater  = 1'b0;
      assign p_valid    = 1'b0;
      assign p_address  = new_address;
      assign p_distance = new_distance;
      assign p_id       = new_id;
    end else begin : g_inner
      assign p_greater  = c_greater[i-1];
      assign p_valid    = c_valid[i-1];
      assign p_address  = c_address[i-1];
      assign p_distance = c_distance[i-1];
      assign p_id       = c_id[i-1];
    end

    if (i == MAX_KEEP - 1) begin : g_tail
      assign n_valid    = 1'b0;
      assign n_address  = c_address[i];
      assign n_distance = c_distance[i];
      assign n_id       = c_id[i];
    end else begin : g_body
      assign n_valid    = c_valid[i+1];
      assign n_address  = c_address[i+1];
      assign n_distance = c_distance[i+1];
      assign n_id       = c_id[i+1];
    end

    nat_cell #(.ID_BITS(ID_BITS)) u_cell (
      .clk           (clk),
      .rst           (rst),
      .ctl           (ctl),
      .new_address   (new_address),
      .new_distance  (new_distance),
      .new_id        (new_id),
      .prev_greater  (p_greater),
      .prev_valid    (p_valid),
      .prev_address  (p_address),
      .prev_distance (p_distance),
      .prev_id       (p_id),
      .next_valid    (n_valid),
      .next_address  (n_address),
      .next_distance (n_distance),
      .next_id       (n_id),
      .greater       (c_greater[i]),
      .take_new      (c_take[i]),
      .valid         (c_valid[i]),
      .address       (c_address[i]),
      .distance      (c_distance[i]),
      .id            (c_id[i])
    );

    assign take_vec[i] = c_take[i];
  end

  assign inserted      = |take_vec;
  assign head_address  = c_address[0];
  assign head_distance = c_distance[0];
  assign head_id       = c_id[0];

endmodule

// ----- hdl/nat_front.sv -----
// Input register, qualification and distance stage
`timescale 1ns / 1ps

module nat_front #(
  parameter int ID_BITS = nat_pkg::ID_BITS_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       accept,
  input  logic [nat_pkg::ADDR_W-1:0] symbol_address,
  input  logic [15:0]                symbol_id,
  input  logic                       is_function,
  input  logic                       excluded,
  input  logic                       last_symbol,
  input  logic                       mode,
  input  logic [nat_pkg::ADDR_W-1:0] query,
  input  logic [nat_pkg::ADDR_W-1:0] text_start,
  input  logic [nat_pkg::ADDR_W-1:0] text_length,
  output nat_pkg::stage_t            stage,
  output logic [nat_pkg::ADDR_W-1:0] out_address,
  output logic [nat_pkg::ADDR_W-1:0] calc_distance,
  output logic [ID_BITS-1:0]         out_id
);

  logic                       s1_valid;
  logic                       s1_last;
  logic                       s1_func;
  logic                       s1_excl;
  logic [nat_pkg::ADDR_W-1:0] s1_address;
  logic [ID_BITS-1:0]         s1_id;

  logic                       in_range;
  logic                       ok;
  logic [nat_pkg::ADDR_W-1:0] rel;
  logic [nat_pkg::ADDR_W-1:0] q_low;
  logic [nat_pkg::ADDR_W-1:0] a_low;
  logic [nat_pkg::ADDR_W-1:0] dist_full;
  logic [nat_pkg::ADDR_W-1:0] dist_page;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_address <= symbol_address;
      s1_id      <= ID_BITS'(symbol_id);
      s1_func    <= is_function;
      s1_excl    <= excluded;
      s1_last    <= last_symbol;
    end
  end

  always_comb begin
    rel       = s1_address - text_start;
    in_range  = (s1_address >= text_start) && (rel < text_length);
    ok        = s1_func && !s1_excl && (s1_address != '0) && (!mode || in_range);
    dist_full = (s1_address > query) ? (s1_address - query) : (query - s1_address);
    q_low     = query & nat_pkg::PAGE_MASK;
    a_low     = s1_address & nat_pkg::PAGE_MASK;
    dist_page = (a_low > q_low) ? (a_low - q_low) : (q_low - a_low);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stage.valid <= 1'b0;
    end else begin
      stage.valid <= s1_valid;
    end
    stage.ok   <= ok;
    stage.last <= s1_last;
  end

  always_ff @(posedge clk) begin
    out_address   <= s1_address;
    out_id        <= s1_id;
    calc_distance <= mode ? dist_page : dist_full;
  end

endmodule

// ----- hdl/nearest_address_top_k_top.sv -----
// Top level: config registers, run control and result output
// Accepts one symbol record per cycle while busy is low.
// The first result beat follows the last record through the input register, the distance
// stage, the cell insert and the output register; then one beat per cycle, max(1, reported
// entries) beats in all, the chain popping one entry per beat; busy drops with the last beat.
// Synchronous reset clears cell valid bits, entry count, control and config; no receiver stall.
`timescale 1ns / 1ps
`include "nearest_address_top_k_top_defines.svh"

module nearest_address_top_k_top #(
  parameter int MAX_KEEP = nat_pkg::MAX_KEEP_DEF,
  parameter int ID_BITS  = nat_pkg::ID_BITS_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  output logic                       busy,
  input  logic [nat_pkg::ADDR_W-1:0] symbol_address,
  input  logic [15:0]                symbol_id,
  input  logic                       is_function,
  input  logic                       excluded,
  input  logic                       last_symbol,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [nat_pkg::IDX_W-1:0]  cfg_index,
  input  logic [nat_pkg::ADDR_W-1:0] cfg_data,
  output logic                       result_valid,
  output logic                       status,
  output logic [3:0]                 rank,
  output logic [15:0]                match_id,
  output logic [nat_pkg::ADDR_W-1:0] match_address,
  output logic [nat_pkg::ADDR_W-1:0] match_distance,
  output logic [6:0]                 confidence,
  output logic [nat_pkg::ADDR_W-1:0] base_estimate,
  output logic                       last_result
);

  localparam int CW = $clog2(MAX_KEEP + 1);

  typedef enum logic [2:0] {
    ST_RUN   = 3'b001,
    ST_DRAIN = 3'b010,
    ST_EMIT  = 3'b100
  } state_t;

  state_t state;
  state_t state_next;

  logic                       distance_mode;
  logic [nat_pkg::ADDR_W-1:0] query_address;
  logic [nat_pkg::ADDR_W-1:0] text_start;
  logic [nat_pkg::ADDR_W-1:0] text_length;
  logic [4:0]                 keep_count;

  logic                       accept;
  nat_pkg::stage_t            stage;
  logic [nat_pkg::ADDR_W-1:0] f_address;
  logic [nat_pkg::ADDR_W-1:0] f_distance;
  logic [ID_BITS-1:0]         f_id;

  nat_pkg::cell_ctl_t         ctl;
  logic                       inserted;
  logic [nat_pkg::ADDR_W-1:0] head_address;
  logic [nat_pkg::ADDR_W-1:0] head_distance;
  logic [ID_BITS-1:0]         head_id;

  logic [CW-1:0] total;
  logic [CW-1:0] beat;
  logic [CW-1:0] limit;
  logic [CW-1:0] count;
  logic          emit;
  logic          empty;
  logic          final_beat;

  logic [18:0] conf_x;
  logic [6:0]  conf_q0;
  logic [12:0] conf_r;
  logic [6:0]  conf_q;
  logic [6:0]  conf;

  assign cfg_ready = 1'b1;
  assign busy      = (state != ST_RUN);
  assign accept    = start && !busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      distance_mode <= 1'b0;
      query_address <= '0;
      text_start    <= '0;
      text_length   <= '0;
      keep_count    <= nat_pkg::KEEP_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        nat_pkg::REG_MODE:       distance_mode <= cfg_data[0];
        nat_pkg::REG_QUERY:      query_address <= cfg_data;
        nat_pkg::REG_TEXT_START: text_start    <= cfg_data;
        nat_pkg::REG_TEXT_LEN:   text_length   <= cfg_data;
        nat_pkg::REG_KEEP:       keep_count    <= cfg_data[4:0];
        default: ;
      endcase
    end
  end

  nat_front #(.ID_BITS(ID_BITS)) u_front (
    .clk            (clk),
    .rst            (rst),
    .accept         (accept),
    .symbol_address (symbol_address),
    .symbol_id      (symbol_id),
    .is_function    (is_function),
    .excluded       (excluded),
    .last_symbol    (last_symbol),
    .mode           (distance_mode),
    .query          (query_address),
    .text_start     (text_start),
    .text_length    (text_length),
    .stage          (stage),
    .out_address    (f_address),
    .calc_distance  (f_distance),
    .out_id         (f_id)
  );

  always_comb begin
    if (keep_count == '0 || int'(keep_count) > MAX_KEEP) begin
      limit = CW'(MAX_KEEP);
    end else begin
      limit = CW'(keep_count);
    end
    count      = (limit < total) ? limit : total;
    emit       = (state == ST_EMIT);
    empty      = (total == '0);
    final_beat = empty || (beat + CW'(1) == count);
    ctl.ins    = stage.valid && stage.ok;
    ctl.pop    = emit;
    ctl.clr    = emit && final_beat;
  end

  nat_chain #(.MAX_KEEP(MAX_KEEP), .ID_BITS(ID_BITS)) u_chain (
    .clk           (clk),
    .rst           (rst),
    .ctl           (ctl),
    .new_address   (f_address),
    .new_distance  (f_distance),
    .new_id        (f_id),
    .inserted      (inserted),
    .head_address  (head_address),
    .head_distance (head_distance),
    .head_id       (head_id)
  );

  always_comb begin
    state_next = state;
    unique case (state)
      ST_RUN: begin
        if (accept && last_symbol) state_next = ST_DRAIN;
      end
      ST_DRAIN: begin
        if (stage.valid && stage.last) state_next = ST_EMIT;
      end
      ST_EMIT: begin
        if (final_beat) state_next = ST_RUN;
      end
      default: state_next = ST_RUN;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_RUN;
      total <= '0;
      beat  <= '0;
    end else begin
      state <= state_next;
      if (ctl.clr) begin
        total <= '0;
      end else if (inserted && total != CW'(MAX_KEEP)) begin
        total <= total + CW'(1);
      end
      if (ctl.clr) begin
        beat <= '0;
      end else if (emit) begin
        beat <= beat + CW'(1);
      end
    end
  end

  // ceil(100*d/4095) via x/4095 = (x>>12) plus one correction
  always_comb begin
    conf_x  = 19'(head_distance[11:0]) * 19'(nat_pkg::CONF_FULL)
            + 19'(nat_pkg::CONF_SPAN) - 19'd1;
    conf_q0 = conf_x[18:12];
    conf_r  = 13'(conf_x[11:0]) + 13'(conf_q0);
    conf_q  = conf_q0 + ((conf_r >= 13'(nat_pkg::CONF_SPAN)) ? 7'd1 : 7'd0);
    if (head_distance > 64'(nat_pkg::CONF_SPAN)) begin
      conf = '0;
    end else begin
      conf = nat_pkg::CONF_FULL - conf_q;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else begin
      result_valid <= emit;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      last_result <= final_beat;
      if (empty) begin
        status         <= 1'b1;
        rank           <= '0;
        match_id       <= '0;
        match_address  <= '0;
        match_distance <= '0;
        confidence     <= '0;
        base_estimate  <= '0;
      end else begin
        status         <= 1'b0;
        rank           <= 4'(beat);
        match_id       <= 16'(head_id);
        match_address  <= head_address;
        match_distance <= head_distance;
        confidence     <= conf;
        base_estimate  <= (query_address - head_address) & ~nat_pkg::PAGE_MASK;
      end
    end
  end

  `NAT_ASSERT_NEXT(a_beats_contiguous, result_valid && !last_result, result_valid, "beat gap")
  `NAT_ASSERT_NEXT(a_busy_after_last, accept && last_symbol, busy, "busy low after last")
  `NAT_ASSERT_NOW(a_empty_is_final, result_valid && status, last_result, "empty beat not final")
  `NAT_ASSERT_NOW(a_no_insert_in_emit, emit, !ctl.ins, "insert during result drain")

endmodule

// ----- dv/tb_nearest_address_top_k_top.sv -----
// Self-checking testbench for the nearest address top-k block: directed table, then random sets
`timescale 1ns / 1ps

module tb_nearest_address_top_k_top;
  import nat_pkg::*;

  localparam int LIST_DEPTH   = MAX_KEEP_DEF;
  localparam int RANDOM_ITEMS = 410;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int DRAIN_CYCLES = 8;
  localparam int TAIL_ITEMS   = 60;
  localparam logic [IDX_W-1:0] REG_SPARE = 3'd7;
  localparam logic STATUS_HIT  = 1'b0;
  localparam logic STATUS_NONE = 1'b1;

  typedef struct packed {
    logic [ADDR_W-1:0] addr;
    logic [15:0]       id;
    logic              func;
    logic              excl;
    logic              last;
  } sym_t;

  typedef struct packed {
    logic              status;
    logic [3:0]        rank;
    logic [15:0]       id;
    logic [ADDR_W-1:0] addr;
    logic [ADDR_W-1:0] distance;
    logic [6:0]        conf;
    logic [ADDR_W-1:0] base;
    logic              last;
  } match_t;

  typedef struct packed {
    logic              is_reg;
    logic [IDX_W-1:0]  idx;
    logic [ADDR_W-1:0] data;
    sym_t              sym;
    logic              typed;
    match_t            fixed;
  } dir_row_t;

  logic              clk;
  logic              rst;
  logic              start;
  logic              busy;
  logic [ADDR_W-1:0] symbol_address;
  logic [15:0]       symbol_id;
  logic              is_function;
  logic              excluded;
  logic              last_symbol;
  logic              cfg_valid;
  logic              cfg_ready;
  logic [IDX_W-1:0]  cfg_index;
  logic [ADDR_W-1:0] cfg_data;
  logic              result_valid;
  logic              status;
  logic [3:0]        rank;
  logic [15:0]       match_id;
  logic [ADDR_W-1:0] match_address;
  logic [ADDR_W-1:0] match_distance;
  logic [6:0]        confidence;
  logic [ADDR_W-1:0] base_estimate;
  logic              last_result;

  nearest_address_top_k_top u_top (
    .clk            (clk),
    .rst            (rst),
    .start          (start),
    .busy           (busy),
    .symbol_address (symbol_address),
    .symbol_id      (symbol_id),
    .is_function    (is_function),
    .excluded       (excluded),
    .last_symbol    (last_symbol),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .result_valid   (result_valid),
    .status         (status),
    .rank           (rank),
    .match_id       (match_id),
    .match_address  (match_address),
    .match_distance (match_distance),
    .confidence     (confidence),
    .base_estimate  (base_estimate),
    .last_result    (last_result)
  );

  // shadow of the register file
  logic              cur_mode;
  logic [ADDR_W-1:0] cur_query;
  logic [ADDR_W-1:0] cur_text_start;
  logic [ADDR_W-1:0] cur_text_len;
  logic [4:0]        cur_keep;

  // shadow of the sorted nearest list
  logic [ADDR_W-1:0] near_addr [LIST_DEPTH];
  logic [ADDR_W-1:0] near_dist [LIST_DEPTH];
  logic [15:0]       near_id   [LIST_DEPTH];
  int                near_count;

  match_t   step_matches[$];
  match_t   awaited[$];
  match_t   head;
  dir_row_t table_rows[$];

  int errors;
  int sent;
  int beats;
  int reg_writes;
  int sets;
  int cycles;

  initial begin
    clk = 1'b0;
  end

  always #1 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results still awaited", cycles, awaited.size());
      $display("status: fail");
      $finish;
    end
  end

  task automatic report_mismatch(input string what, input logic [ADDR_W-1:0] want_v,
                                 input logic [ADDR_W-1:0] got_v);
    errors++;
    if (errors <= 60)
      $display("mismatch %s: expected %h got %h (cycle %0d)", what, want_v, got_v, cycles);
  endtask

  // every result beat must match the oldest awaited one
  always @(posedge clk) begin
    if (!rst && result_valid === 1'b1) begin
      beats++;
      if (awaited.size() == 0) begin
        report_mismatch("unexpected result beat, match_id", '0, match_id);
      end else begin
        head = awaited.pop_front();
        if (status !== head.status) report_mismatch("status", head.status, status);
        if (rank !== head.rank) report_mismatch("rank", head.rank, rank);
        if (match_id !== head.id) report_mismatch("match_id", head.id, match_id);
        if (match_address !== head.addr)
          report_mismatch("match_address", head.addr, match_address);
        if (match_distance !== head.distance)
          report_mismatch("match_distance", head.distance, match_distance);
        if (confidence !== head.conf) report_mismatch("confidence", head.conf, confidence);
        if (base_estimate !== head.base)
          report_mismatch("base_estimate", head.base, base_estimate);
        if (last_result !== head.last)
          report_mismatch("last_result", head.last, last_result);
      end
    end
  end

  function automatic logic [ADDR_W-1:0] abs_gap(input logic [ADDR_W-1:0] x,
                                               input logic [ADDR_W-1:0] y);
    return (x > y) ? x - y : y - x;
  endfunction

  function automatic logic [ADDR_W-1:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // updates the nearest list and leaves the results of this record in step_matches
  task automatic rank_symbol(input sym_t s);
    logic              ok;
    logic [ADDR_W-1:0] d;
    logic [ADDR_W-1:0] t;
    int                pos;
    int                i;
    int                k;
    int                n;
    match_t            m;
    ok = s.func && s.addr != '0 && !s.excl;
    if (ok && cur_mode)
      if (s.addr < cur_text_start || s.addr - cur_text_start >= cur_text_len) ok = 1'b0;
    if (ok) begin
      d = cur_mode ? abs_gap(cur_query & PAGE_MASK, s.addr & PAGE_MASK)
                   : abs_gap(cur_query, s.addr);
      pos = near_count;
      while (pos > 0 && near_dist[pos-1] > d) pos--;
      if (pos < LIST_DEPTH) begin
        i = (near_count < LIST_DEPTH) ? near_count : LIST_DEPTH - 1;
        while (i > pos) begin
          near_addr[i] = near_addr[i-1];
          near_dist[i] = near_dist[i-1];
          near_id[i]   = near_id[i-1];
          i--;
        end
        near_addr[pos] = s.addr;
        near_dist[pos] = d;
        near_id[pos]   = s.id;
        if (near_count < LIST_DEPTH) near_count++;
      end
    end
    step_matches.delete();
    if (s.last) begin
      if (near_count == 0) begin
        m = '0;
        m.status = STATUS_NONE;
        m.last = 1'b1;
        step_matches.push_back(m);
      end else begin
        n = (cur_keep == 0 || cur_keep > LIST_DEPTH) ? LIST_DEPTH : int'(cur_keep);
        if (n > near_count) n = near_count;
        for (k = 0; k < n; k++) begin
          m.status = STATUS_HIT;
          m.rank = 4'(k);
          m.id = near_id[k];
          m.addr = near_addr[k];
          m.distance = near_dist[k];
          t = 64'd100 * near_dist[k] + 64'(CONF_SPAN) - 64'd1;
          t = 64'(CONF_FULL) - t / 64'(CONF_SPAN);
          m.conf = (near_dist[k] > 64'(CONF_SPAN)) ? 7'd0 : t[6:0];
          m.base = (cur_query - near_addr[k]) & ~PAGE_MASK;
          m.last = (k == n - 1);
          step_matches.push_back(m);
        end
        near_count = 0;
      end
    end
  endtask

  // one record beat; typed rows replace the predicted result
  task automatic issue(input sym_t s, input logic typed, input match_t fixed);
    start          <= 1'b1;
    symbol_address <= s.addr;
    symbol_id      <= s.id;
    is_function    <= s.func;
    excluded       <= s.excl;
    last_symbol    <= s.last;
    do @(posedge clk); while (busy !== 1'b0);
    sent++;
    rank_symbol(s);
    if (typed) awaited.push_back(fixed);
    else foreach (step_matches[i]) awaited.push_back(step_matches[i]);
  endtask

  task automatic idle_burst(input int n);
    start <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  // hold off until every awaited result is out and the pipeline is empty
  task automatic settle();
    start <= 1'b0;
    while (awaited.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [ADDR_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    reg_writes++;
    case (idx)
      REG_MODE:       cur_mode = data[0];
      REG_QUERY:      cur_query = data;
      REG_TEXT_START: cur_text_start = data;
      REG_TEXT_LEN:   cur_text_len = data;
      REG_KEEP:       cur_keep = data[4:0];
      default: ;
    endcase
  endtask

  // phase 0 drives every register to all ones, phase 1 to zero, later phases random
  task automatic reconfigure(input int phase);
    logic [ADDR_W-1:0] v;
    logic              every;
    every = (phase < 2);
    if (every || $urandom_range(0, 1) == 1) begin
      v = (phase == 0) ? '1 : (phase == 1) ? '0 : 64'($urandom_range(0, 1));
      if (phase >= 2 && $urandom_range(0, 3) == 0) v = {63'(rand64()), v[0]};
      write_reg(REG_MODE, v);
    end
    if (every || $urandom_range(0, 1) == 1) begin
      case ($urandom_range(0, 3))
        0: v = rand64();
        1: v = 64'($urandom_range(0, 8191));
        2: v = ~64'($urandom_range(0, 8191));
        default: v = {$urandom, 20'($urandom), 12'($urandom_range(0, 4095))};
      endcase
      if (phase == 0) v = '1;
      if (phase == 1) v = '0;
      write_reg(REG_QUERY, v);
    end
    if (every || $urandom_range(0, 1) == 1) begin
      case ($urandom_range(0, 3))
        0: v = '0;
        1: v = rand64();
        2: v = 64'($urandom_range(0, 65535)) << 12;
        default: v = '1 - 64'($urandom_range(0, 65535));
      endcase
      if (phase == 0) v = '1;
      if (phase == 1) v = '0;
      write_reg(REG_TEXT_START, v);
    end
    if (every || $urandom_range(0, 1) == 1) begin
      case ($urandom_range(0, 7))
        0: v = '0;
        1, 2, 3: v = 64'($urandom_range(1, 16384));
        4, 5: v = rand64();
        default: v = '1;
      endcase
      if (phase == 0) v = '1;
      if (phase == 1) v = '0;
      write_reg(REG_TEXT_LEN, v);
    end
    if (every || $urandom_range(0, 1) == 1) begin
      v = ($urandom_range(0, 3) == 0) ? 64'($urandom_range(0, 31))
                                      : 64'($urandom_range(1, LIST_DEPTH));
      if ($urandom_range(0, 3) == 0) v = {59'(rand64()), v[4:0]};
      if (phase == 0) v = '1;
      if (phase == 1) v = '0;
      write_reg(REG_KEEP, v);
    end
    cfg_valid <= 1'b0;
  endtask

  // well-formed records land near the query, in the text range, on prev or at random
  function automatic sym_t make_symbol(input logic good, input logic [ADDR_W-1:0] prev);
    sym_t              s;
    logic [ADDR_W-1:0] lim;
    logic [ADDR_W-1:0] off;
    int                pick;
    s.id = 16'($urandom_range(0, 65535));
    s.last = 1'b0;
    if (!good) begin
      s.addr = ($urandom_range(0, 5) == 0) ? '0 : rand64();
      s.func = 1'($urandom_range(0, 1));
      s.excl = 1'($urandom_range(0, 1));
      return s;
    end
    s.func = 1'b1;
    s.excl = 1'b0;
    pick = $urandom_range(0, 9);
    if (pick >= 8 && prev != '0) begin
      s.addr = prev;
    end else if (pick >= 6) begin
      s.addr = rand64();
    end else if (cur_mode && cur_text_len != '0) begin
      lim = ~cur_text_start;
      if (cur_text_len - 1 < lim) lim = cur_text_len - 1;
      if (lim <= 64'h7FFF) off = 64'($urandom_range(0, 32'(lim)));
      else if ($urandom_range(0, 1) == 1) off = 64'($urandom_range(0, 32'h7FFF));
      else if (lim == '1) off = rand64();
      else off = rand64() % (lim + 1);
      s.addr = cur_text_start + off;
    end else begin
      off = 64'($urandom_range(0, 6000));
      s.addr = ($urandom_range(0, 1) == 1) ? cur_query + off : cur_query - off;
    end
    if (s.addr == '0) s.addr = 64'd1;
    return s;
  endfunction

  function automatic dir_row_t sym_row(input logic [ADDR_W-1:0] a, input logic [15:0] id,
                                       input logic f, input logic e, input logic l);
    dir_row_t r;
    r = '0;
    r.sym = '{addr: a, id: id, func: f, excl: e, last: l};
    return r;
  endfunction

  function automatic dir_row_t none_row(input logic [ADDR_W-1:0] a, input logic [15:0] id,
                                        input logic f, input logic e);
    dir_row_t r;
    r = sym_row(a, id, f, e, 1'b1);
    r.typed = 1'b1;
    r.fixed = '0;
    r.fixed.status = STATUS_NONE;
    r.fixed.last = 1'b1;
    return r;
  endfunction

  function automatic dir_row_t reg_row(input logic [IDX_W-1:0] i, input logic [ADDR_W-1:0] v);
    dir_row_t r;
    r = '0;
    r.is_reg = 1'b1;
    r.idx = i;
    r.data = v;
    return r;
  endfunction

  initial begin
    dir_row_t          r;
    sym_t              s;
    logic [ADDR_W-1:0] prev_addr;
    int                rand_items;
    int                len;
    int                j;
    int                phase;
    logic              quiet;

    rst = 1'b1;
    start = 1'b0;
    symbol_address = '0;
    symbol_id = '0;
    is_function = 1'b0;
    excluded = 1'b0;
    last_symbol = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    errors = 0;
    sent = 0;
    beats = 0;
    reg_writes = 0;
    sets = 0;
    cycles = 0;
    cur_mode = 1'b0;
    cur_query = '0;
    cur_text_start = '0;
    cur_text_len = '0;
    cur_keep = KEEP_RESET;
    near_count = 0;
    prev_addr = '0;
    rand_items = 0;

    // reset config: full distance, query 0, keep 5
    table_rows.push_back(none_row(64'd0, 16'h0000, 1'b1, 1'b0));
    r = sym_row(64'h1234, 16'hFFFF, 1'b1, 1'b0, 1'b1);
    r.typed = 1'b1;
    r.fixed = '{status: STATUS_HIT, rank: 4'd0, id: 16'hFFFF, addr: 64'h1234,
                distance: 64'h1234, conf: 7'd0, base: 64'hFFFF_FFFF_FFFF_E000, last: 1'b1};
    table_rows.push_back(r);
    table_rows.push_back(none_row(64'h5, 16'h0001, 1'b1, 1'b1));
    table_rows.push_back(none_row(64'h5, 16'h0002, 1'b0, 1'b0));
    // address extremes around a mid-range query, with a tie and the confidence edges
    table_rows.push_back(reg_row(REG_QUERY, 64'h8000_0000_0000_0000));
    table_rows.push_back(reg_row(REG_KEEP, 64'd16));
    table_rows.push_back(sym_row(64'hFFFF_FFFF_FFFF_FFFF, 16'h0010, 1'b1, 1'b0, 1'b0));
    table_rows.push_back(sym_row(64'h1, 16'h0011, 1'b1, 1'b0, 1'b0));
    table_rows.push_back(sym_row(64'h8000_0000_0000_0FFF, 16'h0012, 1'b1, 1'b0, 1'b0));
    table_rows.push_back(sym_row(64'h7FFF_FFFF_FFFF_FFFF, 16'h0013, 1'b1, 1'b0, 1'b0));
    table_rows.push_back(sym_row(64'h8000_0000_0000_0000, 16'h0014, 1'b1, 1'b0, 1'b1));
    r = sym_row(64'h8000_0000_0000_0000, 16'hA5A5, 1'b1, 1'b0, 1'b1);
    r.typed = 1'b1;
    r.fixed = '{status: STATUS_HIT, rank: 4'd0, id: 16'hA5A5, addr: 64'h8000_0000_0000_0000,
                distance: 64'd0, conf: CONF_FULL, base: 64'd0, last: 1'b1};
    table_rows.push_back(r);
    // page offset mode with range edges on both sides
    table_rows.push_back(reg_row(REG_MODE, 64'd1));
    table_rows.push_back(reg_row(REG_TEXT_START, 64'h1000));
    table_rows.push_back(reg_row(REG_TEXT_LEN, 64'h2000));
    table_rows.push_back(reg_row(REG_QUERY, 64'hFFFF_FFFF_FFFF_FABC));
    table_rows.push_back(sym_row(64'h0FFF, 16'h0020, 1'b1, 1'b0, 1'b0));
    table_rows.push_back(sym_row(64'h1000, 16'h0021, 1'b1, 1'b0, 1'b0));
    table_rows.push_back(sym_row(64'h2FFF, 16'h0022, 1'b1, 1'b0, 1'b0));
    table_rows.push_back(sym_row(64'h3000, 16'h0023, 1'b1, 1'b0, 1'b0));
    table_rows.push_back(sym_row(64'h1ABC, 16'h0024, 1'b1, 1'b0, 1'b1));
    table_rows.push_back(reg_row(REG_TEXT_LEN, 64'd0));
    table_rows.push_back(none_row(64'h1000, 16'h0025, 1'b1, 1'b0));
    // keep 1 at set start, widened to 0 (all) before the last record
    table_rows.push_back(reg_row(REG_KEEP, 64'd1));
    table_rows.push_back(reg_row(REG_MODE, 64'd0));
    table_rows.push_back(sym_row(64'h10, 16'h0030, 1'b1, 1'b0, 1'b0));
    table_rows.push_back(sym_row(64'h20, 16'h0031, 1'b1, 1'b0, 1'b0));
    table_rows.push_back(reg_row(REG_KEEP, 64'd0));
    table_rows.push_back(reg_row(REG_SPARE, 64'hDEAD_BEEF_0123_4567));
    table_rows.push_back(sym_row(64'hFFFF_FFFF_FFFF_FFF0, 16'h0032, 1'b1, 1'b0, 1'b1));
    // text range at the top of the address space
    table_rows.push_back(reg_row(REG_KEEP, 64'd31));
    table_rows.push_back(reg_row(REG_MODE, 64'd1));
    table_rows.push_back(reg_row(REG_TEXT_START, 64'hFFFF_FFFF_FFFF_F000));
    table_rows.push_back(reg_row(REG_TEXT_LEN, 64'hFFFF_FFFF_FFFF_FFFF));
    table_rows.push_back(sym_row(64'hFFFF_FFFF_FFFF_FFFF, 16'h0040, 1'b1, 1'b0, 1'b0));
    table_rows.push_back(sym_row(64'h5, 16'h0041, 1'b1, 1'b0, 1'b0));
    table_rows.push_back(sym_row(64'hFFFF_FFFF_FFFF_F001, 16'h0042, 1'b1, 1'b0, 1'b1));

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    foreach (table_rows[i]) begin
      if (table_rows[i].is_reg) begin
        settle();
        write_reg(table_rows[i].idx, table_rows[i].data);
        cfg_valid <= 1'b0;
      end else begin
        issue(table_rows[i].sym, table_rows[i].typed, table_rows[i].fixed);
        if (table_rows[i].sym.last) sets++;
      end
    end

    phase = 0;
    while (rand_items < RANDOM_ITEMS) begin
      if (phase < 2 ||
          (RANDOM_ITEMS - rand_items >= TAIL_ITEMS && $urandom_range(0, 2) == 0)) begin
        settle();
        reconfigure(phase);
        phase++;
      end
      len = ($urandom_range(0, 6) == 0) ? $urandom_range(1, 2) : $urandom_range(3, 24);
      quiet = ($urandom_range(0, 2) == 0) || (RANDOM_ITEMS - rand_items < TAIL_ITEMS);
      for (j = 0; j < len; j++) begin
        if (!quiet && $urandom_range(0, 5) == 0) idle_burst($urandom_range(1, 16));
        if (!quiet && j != len - 1 && $urandom_range(0, 39) == 0) begin
          settle();
          reconfigure(2);
        end
        s = make_symbol($urandom_range(0, 3) != 0, prev_addr);
        s.last = (j == len - 1);
        prev_addr = s.addr;
        issue(s, 1'b0, '0);
        rand_items++;
      end
      sets++;
    end

    start <= 1'b0;
    while (awaited.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    $display("covered %0d symbol records in %0d sets, %0d result beats, %0d register writes",
             sent, sets, beats, reg_writes);
    $display("random part went through %0d register settings; %0d mismatches", phase, errors);
    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// ----- files.f -----
+incdir+hdl
hdl/nat_pkg.sv
hdl/nat_cell.sv
hdl/nat_chain.sv
hdl/nat_front.sv
hdl/nearest_address_top_k_top.sv
dv/tb_nearest_address_top_k_top.sv
